// ===== sv/ilcr_pkg.sv =====
// Shared types and constants for the IRQ least-count core router.
`timescale 1ns / 1ps

package ilcr_pkg;

	localparam int CNT_W  = 64;
	localparam int DIV_W  = 16;
	localparam int STEP_W = 6;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;
	localparam int ACT_W  = 5;

	localparam logic [CFG_AW-1:0] CFG_SYMMETRIC = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_BALANCE   = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_ACTIVE    = 2'd2;
	localparam logic [CFG_AW-1:0] CFG_DIVISOR   = 2'd3;

	localparam logic [ACT_W-1:0] ACTIVE_RESET  = 5'd1;
	localparam logic [DIV_W-1:0] DIVISOR_RESET = 16'd10;

	typedef enum logic {
		ALU_MOD,
		ALU_CMP
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [DIV_W-1:0] rem;
		logic             in_bit;
		logic [DIV_W-1:0] divisor;
		logic [CNT_W-1:0] val;
		logic [CNT_W-1:0] cur_min;
	} alu_req_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem_next;
		logic             lt;
		logic             near_top;
	} alu_res_t;

endpackage

// ===== sv/ilcr_count_ram.sv =====
// Count table memory with one port and a registered read.
`timescale 1ns / 1ps

module ilcr_count_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             addr,
	input  logic [ilcr_pkg::CNT_W-1:0] wdata,
	output logic [ilcr_pkg::CNT_W-1:0] rdata
);

	logic [ilcr_pkg::CNT_W-1:0] mem_q [DEPTH];
	logic [ilcr_pkg::CNT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/ilcr_alu.sv =====
// Shared subtractor used for the serial remainder and the minimum search.
`timescale 1ns / 1ps

module ilcr_alu (
	input  ilcr_pkg::alu_req_t req,
	output ilcr_pkg::alu_res_t res
);

	logic [ilcr_pkg::CNT_W-1:0] op_a;
	logic [ilcr_pkg::CNT_W-1:0] op_b;
	logic [ilcr_pkg::CNT_W:0]   diff;
	logic [ilcr_pkg::DIV_W:0]   shifted;

	always_comb begin
		shifted = {req.rem, req.in_bit};
		case (req.op)
			ilcr_pkg::ALU_MOD: begin
				op_a = ilcr_pkg::CNT_W'(shifted);
				op_b = ilcr_pkg::CNT_W'(req.divisor);
			end
			ilcr_pkg::ALU_CMP: begin
				op_a = req.val;
				op_b = req.cur_min;
			end
			default: begin
				op_a = req.val;
				op_b = req.cur_min;
			end
		endcase
		diff = {1'b0, op_a} - {1'b0, op_b};
		res.lt = diff[ilcr_pkg::CNT_W];
		res.rem_next = diff[ilcr_pkg::CNT_W] ? shifted[ilcr_pkg::DIV_W-1:0]
			: diff[ilcr_pkg::DIV_W-1:0];
		res.near_top = &req.val[ilcr_pkg::CNT_W-1:1];
	end

endmodule

// ===== sv/irq_least_count_core_router_unit.sv =====
// Top level: sequencer, configuration registers and result register of the router.
// An out-of-range item goes straight to the result. Otherwise the count is read and
// incremented; with balancing on, a serial remainder over the 64-bit count by the divisor
// follows, and if it is zero a scan of the active cores' counts, then a clear of those
// counts when one is near the top. Input is ready again when the result is registered.
// After reset the count table is zeroed one entry per cycle, all MAX_CORES * IRQ_COUNT
// entries, before the first item is taken; configuration resets to its defaults.
`timescale 1ns / 1ps

module irq_least_count_core_router_unit #(
	parameter int MAX_CORES = 16,
	parameter int IRQ_COUNT = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // irq[3:0], core_id[7:4]
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// eoi_to_local[0], route_valid[1], route_core[5:2], counts_cleared[6], zero[7]
	output logic [7:0]                 m_axis_tdata,
	input  logic                       cfg_we,
	input  logic [ilcr_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [ilcr_pkg::CFG_DW-1:0] cfg_data
);

	localparam int DEPTH = MAX_CORES * IRQ_COUNT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NW    = $clog2(MAX_CORES + 1);
	localparam int CNT_W = ilcr_pkg::CNT_W;
	localparam int DIV_W = ilcr_pkg::DIV_W;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_INC,
		ST_MOD,
		ST_SCAN,
		ST_CLR,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic                       sym_q;
	logic                       bal_q;
	logic [ilcr_pkg::ACT_W-1:0] act_q;
	logic [DIV_W-1:0]           div_q;

	logic [AW-1:0]                 init_q;
	logic [3:0]                    core_q;
	logic [AW-1:0]                 base_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [DIV_W-1:0]              rem_q;
	logic [ilcr_pkg::STEP_W-1:0]   step_q;
	logic [NW-1:0]                 scan_n_q;
	logic [NW-1:0]                 scan_idx_q;
	logic                          cmp_vld_s1;
	logic [CW-1:0]                 cmp_idx_s1;
	logic [CNT_W-1:0]              min_q;
	logic [CW-1:0]                 best_q;
	logic                          clr_flag_q;
	logic                          route_valid_q;
	logic [3:0]                    route_core_q;
	logic                          cleared_q;
	logic                          out_vld_q;
	logic [7:0]                    out_data_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_addr;
	logic [CNT_W-1:0]     mem_wdata;
	logic [CNT_W-1:0]     mem_rdata;
	logic [CNT_W-1:0]     cnt_inc;
	logic [DIV_W-1:0]     div_eff;
	logic                 issue;
	logic                 in_range;
	logic [NW-1:0]        scan_n;
	ilcr_pkg::alu_req_t   alu_req;
	ilcr_pkg::alu_res_t   alu_res;

	ilcr_count_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	ilcr_alu u_alu (
		.req(alu_req),
		.res(alu_res)
	);

	assign cnt_inc  = mem_rdata + CNT_W'(1);
	assign div_eff  = (div_q == '0) ? DIV_W'(1) : div_q;
	assign issue    = (scan_idx_q < scan_n_q);
	assign in_range = (int'(s_axis_tdata[3:0]) < IRQ_COUNT)
		&& (int'(s_axis_tdata[7:4]) < MAX_CORES);
	assign scan_n   = (int'(act_q) > MAX_CORES) ? NW'(MAX_CORES) : NW'(act_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = base_q + AW'(core_q);
		mem_wdata = '0;
		case (state_q)
			ST_INIT: begin
				mem_we   = 1'b1;
				mem_addr = init_q;
			end
			ST_INC: begin
				mem_we    = 1'b1;
				mem_wdata = cnt_inc;
			end
			ST_SCAN: begin
				mem_addr = base_q + AW'(scan_idx_q);
			end
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = base_q + AW'(scan_idx_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		alu_req.op      = (state_q == ST_MOD) ? ilcr_pkg::ALU_MOD : ilcr_pkg::ALU_CMP;
		alu_req.rem     = rem_q;
		alu_req.in_bit  = cnt_q[CNT_W-1];
		alu_req.divisor = div_eff;
		alu_req.val     = mem_rdata;
		alu_req.cur_min = min_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= 1'b0;
			bal_q <= 1'b0;
			act_q <= ilcr_pkg::ACTIVE_RESET;
			div_q <= ilcr_pkg::DIVISOR_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				ilcr_pkg::CFG_SYMMETRIC: sym_q <= cfg_data[0];
				ilcr_pkg::CFG_BALANCE:   bal_q <= cfg_data[0];
				ilcr_pkg::CFG_ACTIVE:    act_q <= cfg_data[ilcr_pkg::ACT_W-1:0];
				ilcr_pkg::CFG_DIVISOR:   div_q <= cfg_data[DIV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			init_q        <= '0;
			cmp_vld_s1    <= 1'b0;
			out_vld_q     <= 1'b0;
			route_valid_q <= 1'b0;
			route_core_q  <= '0;
			cleared_q     <= 1'b0;
			clr_flag_q    <= 1'b0;
			scan_idx_q    <= '0;
			scan_n_q      <= '0;
			step_q        <= '0;
		end else begin
			if (out_vld_q && m_axis_tready && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						core_q        <= s_axis_tdata[7:4];
						base_q        <= AW'(int'(s_axis_tdata[3:0]) * MAX_CORES);
						route_valid_q <= 1'b0;
						route_core_q  <= '0;
						cleared_q     <= 1'b0;
						state_q       <= in_range ? ST_RD : ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_INC;
				end
				ST_INC: begin
					cnt_q  <= cnt_inc;
					rem_q  <= '0;
					step_q <= '0;
					state_q <= (bal_q && (cnt_inc != '0)) ? ST_MOD : ST_DONE;
				end
				ST_MOD: begin
					rem_q  <= alu_res.rem_next;
					cnt_q  <= {cnt_q[CNT_W-2:0], 1'b0};
					step_q <= step_q + ilcr_pkg::STEP_W'(1);
					if (step_q == ilcr_pkg::STEP_W'(CNT_W - 1)) begin
						scan_idx_q <= '0;
						scan_n_q   <= scan_n;
						cmp_vld_s1 <= 1'b0;
						min_q      <= '1;
						best_q     <= '0;
						clr_flag_q <= 1'b0;
						state_q    <= (alu_res.rem_next == '0) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue;
					cmp_idx_s1 <= CW'(scan_idx_q);
					if (issue) begin
						scan_idx_q <= scan_idx_q + NW'(1);
					end
					if (cmp_vld_s1) begin
						if (alu_res.lt) begin
							min_q  <= mem_rdata;
							best_q <= cmp_idx_s1;
						end else if (alu_res.near_top) begin
							clr_flag_q <= 1'b1;
						end
					end
					if (!issue && !cmp_vld_s1) begin
						route_valid_q <= 1'b1;
						route_core_q  <= 4'(best_q);
						scan_idx_q    <= '0;
						state_q       <= clr_flag_q ? ST_CLR : ST_DONE;
					end
				end
				ST_CLR: begin
					scan_idx_q <= scan_idx_q + NW'(1);
					if (scan_idx_q == scan_n_q - NW'(1)) begin
						cleared_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_vld_q || m_axis_tready) begin
						out_vld_q  <= 1'b1;
						out_data_q <= {1'b0, cleared_q, route_core_q, route_valid_q, sym_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
